// File: src/sude_pkg.sv
package sude_pkg;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_RXBYTE = 2'd2;
	localparam logic [1:0] OP_TICK  = 2'd3;

	localparam logic KIND_TX     = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
	localparam logic [1:0] STATUS_FRAME   = 2'd2;
	localparam logic [1:0] STATUS_CRC     = 2'd3;

	localparam logic CFG_SLAVE_ADDR = 1'b0;
	localparam logic CFG_TIMEOUT    = 1'b1;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [7:0] FRAME_SYNC = 8'h05;
	localparam logic [7:0] CRC_POLY   = 8'h07;
	localparam logic [7:0] WRITE_FLAG = 8'h80;
	localparam logic [7:0] REG_MASK   = 8'h7F;

	localparam logic [3:0] ECHO_LEN = 4'd4;

	// One byte of CRC-8, data bits taken LSB first.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
		input logic [7:0] data);
		logic [7:0] crc;
		logic [7:0] cur;
		crc = crc_in;
		cur = data;
		for (int b = 0; b < 8; b++) begin
			if (crc[7] ^ cur[0]) begin
				crc = {crc[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				crc = {crc[6:0], 1'b0};
			end
			cur = {1'b0, cur[7:1]};
		end
		return crc;
	endfunction

endpackage

// File: src/sude_cmd_if.sv
interface sude_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [6:0]  reg_num;
	logic [31:0] write_data;
	logic [7:0]  rx_byte;

	modport source (output valid, opcode, reg_num, write_data, rx_byte, input ready);
	modport sink (input valid, opcode, reg_num, write_data, rx_byte, output ready);
endinterface

// File: src/sude_res_if.sv
interface sude_res_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  tx_byte;
	logic        is_last;
	logic [1:0]  status;
	logic [7:0]  reply_addr;
	logic [6:0]  reply_reg;
	logic [31:0] reply_data;

	modport source (output valid, kind, tx_byte, is_last, status, reply_addr, reply_reg,
		reply_data, input ready);
	modport sink (input valid, kind, tx_byte, is_last, status, reply_addr, reply_reg,
		reply_data, output ready);
endinterface

// File: src/sude_cfg_if.sv
interface sude_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [sude_pkg::CFG_INDEX_W-1:0] index;
	logic [sude_pkg::CFG_DATA_W-1:0]  wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

// File: src/stepper_uart_datagram_engine.sv
// Channel  Role    Payload
// cmd      sink    opcode, reg_num, write_data, rx_byte
// res      source  kind, tx_byte, is_last, status, reply_addr, reply_reg, reply_data
// cfg      sink    index, wdata (0 slave address, 1 timeout ticks)
//
// A write request sends eight bytes and a read request four: one byte leaves the output
// register per cycle unless the output stalls, while the shared CRC-8 byte unit folds it
// into the checksum. A received byte or tick is handled in idle; one that closes a request
// yields a status item. A stalled output holds the sequencer in place. Reset clears all
// control state and restores slave address 0 and timeout 1000; no clearing pass is needed.
module stepper_uart_datagram_engine (
	input logic clk,
	input logic arst_n,
	sude_cmd_if.sink cmd,
	sude_res_if.source res,
	sude_cfg_if.sink cfg
);

	typedef enum logic [1:0] {ST_IDLE, ST_TX, ST_RPT} state_t;

	localparam logic [2:0] POS_SYNC = 3'd0;
	localparam logic [2:0] POS_ADDR = 3'd1;
	localparam logic [2:0] POS_REG  = 3'd2;
	localparam logic [2:0] POS_CRC  = 3'd7;
	localparam logic [2:0] READ_LAST = 3'd3;
	localparam logic [2:0] WRITE_LAST = 3'd7;

	state_t      state_q;
	logic [7:0]  slave_addr_q;
	logic [15:0] timeout_q;
	logic        is_write_q;
	logic [6:0]  pend_reg_q;
	logic [31:0] pend_data_q;
	logic        pending_q;
	logic        echo_q;
	logic [3:0]  rx_count_q;
	logic [15:0] wait_q;
	logic [7:0]  crc_q;
	logic [2:0]  byte_idx_q;
	logic        sync_ok_q;
	logic [1:0]  rpt_status_q;
	logic [7:0]  rpt_addr_q;
	logic [6:0]  rpt_reg_q;
	logic [31:0] rpt_data_q;

	logic        out_valid_q;
	logic        out_kind_q;
	logic [7:0]  out_tx_byte_q;
	logic        out_is_last_q;
	logic [1:0]  out_status_q;
	logic [7:0]  out_addr_q;
	logic [6:0]  out_reg_q;
	logic [31:0] out_data_q;

	logic [2:0]  tx_last_idx;
	logic        tx_is_last;
	logic [7:0]  tx_sel;
	logic [7:0]  crc_byte;
	logic [7:0]  crc_nxt;
	logic        out_free;
	logic        out_load;
	logic [3:0]  rx_pos;
	logic [2:0]  frame_pos;
	logic        in_echo;

	assign tx_last_idx = is_write_q ? WRITE_LAST : READ_LAST;
	assign tx_is_last  = (byte_idx_q == tx_last_idx);

	always_comb begin
		unique case (byte_idx_q)
			3'd0: tx_sel = sude_pkg::FRAME_SYNC;
			3'd1: tx_sel = slave_addr_q;
			3'd2: tx_sel = is_write_q ? ({1'b0, pend_reg_q} | sude_pkg::WRITE_FLAG)
				: {1'b0, pend_reg_q};
			3'd3: tx_sel = is_write_q ? pend_data_q[31:24] : crc_q;
			3'd4: tx_sel = pend_data_q[23:16];
			3'd5: tx_sel = pend_data_q[15:8];
			3'd6: tx_sel = pend_data_q[7:0];
			default: tx_sel = crc_q;
		endcase
	end

	// The CRC-8 byte unit is shared by the transmit sequencer and the reply checker.
	assign crc_byte = (state_q == ST_TX) ? tx_sel : cmd.rx_byte;
	assign crc_nxt  = sude_pkg::crc8_byte(crc_q, crc_byte);

	assign out_free  = !out_valid_q || res.ready;
	assign out_load  = ((state_q == ST_TX) || (state_q == ST_RPT)) && out_free;
	assign in_echo   = echo_q && (rx_count_q < sude_pkg::ECHO_LEN);
	assign rx_pos    = rx_count_q - (echo_q ? sude_pkg::ECHO_LEN : 4'd0);
	assign frame_pos = rx_pos[2:0];

	assign cmd.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	assign res.valid      = out_valid_q;
	assign res.kind       = out_kind_q;
	assign res.tx_byte    = out_tx_byte_q;
	assign res.is_last    = out_is_last_q;
	assign res.status     = out_status_q;
	assign res.reply_addr = out_addr_q;
	assign res.reply_reg  = out_reg_q;
	assign res.reply_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			slave_addr_q  <= 8'd0;
			timeout_q     <= 16'd1000;
			is_write_q    <= 1'b0;
			pend_reg_q    <= 7'd0;
			pend_data_q   <= 32'd0;
			pending_q     <= 1'b0;
			echo_q        <= 1'b0;
			rx_count_q    <= 4'd0;
			wait_q        <= 16'd0;
			crc_q         <= 8'd0;
			byte_idx_q    <= 3'd0;
			sync_ok_q     <= 1'b0;
			rpt_status_q  <= sude_pkg::STATUS_OK;
			rpt_addr_q    <= 8'd0;
			rpt_reg_q     <= 7'd0;
			rpt_data_q    <= 32'd0;
			out_valid_q   <= 1'b0;
			out_kind_q    <= sude_pkg::KIND_TX;
			out_tx_byte_q <= 8'd0;
			out_is_last_q <= 1'b0;
			out_status_q  <= sude_pkg::STATUS_OK;
			out_addr_q    <= 8'd0;
			out_reg_q     <= 7'd0;
			out_data_q    <= 32'd0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					sude_pkg::CFG_SLAVE_ADDR: slave_addr_q <= cfg.wdata[7:0];
					sude_pkg::CFG_TIMEOUT:    timeout_q <= cfg.wdata[15:0];
					default: ;
				endcase
			end
			if (out_valid_q && res.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						unique case (cmd.opcode)
							sude_pkg::OP_WRITE, sude_pkg::OP_READ: begin
								is_write_q  <= (cmd.opcode == sude_pkg::OP_WRITE);
								echo_q      <= (cmd.opcode == sude_pkg::OP_READ);
								pend_reg_q  <= cmd.reg_num;
								pend_data_q <= (cmd.opcode == sude_pkg::OP_WRITE)
									? cmd.write_data : 32'd0;
								pending_q   <= 1'b1;
								rx_count_q  <= 4'd0;
								wait_q      <= 16'd0;
								byte_idx_q  <= 3'd0;
								crc_q       <= 8'd0;
								state_q     <= ST_TX;
							end
							sude_pkg::OP_RXBYTE: begin
								if (pending_q) begin
									if (in_echo) begin
										rx_count_q <= rx_count_q + 4'd1;
									end else if (frame_pos == POS_CRC) begin
										pending_q  <= 1'b0;
										rx_count_q <= 4'd0;
										wait_q     <= 16'd0;
										crc_q      <= 8'd0;
										state_q    <= ST_RPT;
										if (!sync_ok_q) begin
											rpt_status_q <= sude_pkg::STATUS_FRAME;
											rpt_addr_q   <= 8'd0;
											rpt_reg_q    <= 7'd0;
											rpt_data_q   <= 32'd0;
										end else if (crc_q != cmd.rx_byte) begin
											rpt_status_q <= sude_pkg::STATUS_CRC;
											rpt_addr_q   <= 8'd0;
											rpt_reg_q    <= 7'd0;
											rpt_data_q   <= 32'd0;
										end else if (is_write_q) begin
											rpt_status_q <= (rpt_data_q == pend_data_q)
												? sude_pkg::STATUS_OK : sude_pkg::STATUS_FRAME;
										end else begin
											rpt_status_q <= (rpt_reg_q == pend_reg_q)
												? sude_pkg::STATUS_OK : sude_pkg::STATUS_FRAME;
										end
									end else begin
										rx_count_q <= rx_count_q + 4'd1;
										crc_q      <= crc_nxt;
										if (frame_pos == POS_SYNC) begin
											sync_ok_q <= (cmd.rx_byte == sude_pkg::FRAME_SYNC);
										end else if (frame_pos == POS_ADDR) begin
											rpt_addr_q <= cmd.rx_byte;
										end else if (frame_pos == POS_REG) begin
											rpt_reg_q <= cmd.rx_byte[6:0];
										end else begin
											rpt_data_q <= {rpt_data_q[23:0], cmd.rx_byte};
										end
									end
								end
							end
							sude_pkg::OP_TICK: begin
								if (pending_q) begin
									if (wait_q >= timeout_q) begin
										pending_q    <= 1'b0;
										rx_count_q   <= 4'd0;
										wait_q       <= 16'd0;
										crc_q        <= 8'd0;
										rpt_status_q <= sude_pkg::STATUS_TIMEOUT;
										rpt_addr_q   <= 8'd0;
										rpt_reg_q    <= 7'd0;
										rpt_data_q   <= 32'd0;
										state_q      <= ST_RPT;
									end else begin
										wait_q <= wait_q + 16'd1;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_TX: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_kind_q    <= sude_pkg::KIND_TX;
						out_tx_byte_q <= tx_sel;
						out_is_last_q <= tx_is_last;
						out_status_q  <= sude_pkg::STATUS_OK;
						out_addr_q    <= 8'd0;
						out_reg_q     <= 7'd0;
						out_data_q    <= 32'd0;
						if (tx_is_last) begin
							crc_q   <= 8'd0;
							state_q <= ST_IDLE;
						end else begin
							crc_q      <= crc_nxt;
							byte_idx_q <= byte_idx_q + 3'd1;
						end
					end
				end
				ST_RPT: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_kind_q    <= sude_pkg::KIND_REPORT;
						out_tx_byte_q <= 8'd0;
						out_is_last_q <= 1'b0;
						out_status_q  <= rpt_status_q;
						out_addr_q    <= rpt_addr_q;
						out_reg_q     <= rpt_reg_q;
						out_data_q    <= rpt_data_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
